// File: rtl/lig_pkg.sv
// Shared types and constants for the linear illumination gradient block.
// Used by every module under rtl/; depends on nothing.
`timescale 1ns / 1ps

package lig_pkg;

	// Channel and configuration port widths
	localparam int CHAN_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int DIR_W      = 2;
	localparam int FACTOR_W   = 4;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FACTOR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

	// Register values after reset
	localparam logic [DIR_W-1:0]      RST_DIRECTION = 2'd0;
	localparam logic [FACTOR_W-1:0]   RST_FACTOR    = 4'd10;
	localparam logic [CFG_DATA_W-1:0] RST_WIDTH     = 13'd1024;
	localparam logic [CFG_DATA_W-1:0] RST_HEIGHT    = 13'd1024;

	// Quotient bits resolved by the restoring divider, one per cycle
	localparam int Q_STEPS = 8;
	localparam int STEP_W  = $clog2(Q_STEPS);

	typedef enum logic [1:0] {
		LANE_IDLE,
		LANE_MUL,
		LANE_DIV,
		LANE_DONE
	} lane_state_t;

	// Position unit controls: accept a beat, advance stage 1 to stage 2
	typedef struct packed {
		logic accept;
		logic adv;
	} pos_ctl_t;

	// Lane controls: start a division, release the finished result
	typedef struct packed {
		logic start;
		logic take;
	} lane_ctl_t;

endpackage

// File: rtl/lig_if.sv
// Valid/ready channel interfaces for pixel beats in and shaded pixel beats out.
// Depends on lig_pkg for the channel width.
`timescale 1ns / 1ps

interface lig_pix_if;
	logic                       valid;
	logic                       ready;
	logic [lig_pkg::CHAN_W-1:0] chan_a;
	logic [lig_pkg::CHAN_W-1:0] chan_b;
	logic [lig_pkg::CHAN_W-1:0] chan_c;

	modport source (output valid, chan_a, chan_b, chan_c, input ready);
	modport sink   (input valid, chan_a, chan_b, chan_c, output ready);
endinterface

interface lig_res_if;
	logic                       valid;
	logic                       ready;
	logic [lig_pkg::CHAN_W-1:0] out_a;
	logic [lig_pkg::CHAN_W-1:0] out_b;
	logic [lig_pkg::CHAN_W-1:0] out_c;
	logic                       frame_last;

	modport source (output valid, out_a, out_b, out_c, frame_last, input ready);
	modport sink   (input valid, out_a, out_b, out_c, frame_last, output ready);
endinterface

// File: rtl/lig_pos.sv
// Raster position counters and ramp numerator/denominator for one pixel.
// Depends on lig_pkg; feeds the three channel lanes.
`timescale 1ns / 1ps

module lig_pos #(
	parameter int MAX_DIM = 4096,
	parameter int DIM_W   = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lig_pkg::pos_ctl_t                 ctl,
	input  logic [lig_pkg::DIR_W-1:0]         direction,
	input  logic [lig_pkg::FACTOR_W-1:0]      factor_tenths,
	input  logic [lig_pkg::CFG_DATA_W-1:0]    frame_width,
	input  logic [lig_pkg::CFG_DATA_W-1:0]    frame_height,
	output logic signed [DIM_W+6:0]           num_s2,
	output logic [DIM_W+3:0]                  den_s2,
	output logic                              last_s2
);

	localparam int CNT_W  = $clog2(MAX_DIM);
	localparam int CMP_W  = (DIM_W > lig_pkg::CFG_DATA_W) ? DIM_W : lig_pkg::CFG_DATA_W;
	localparam int DIFF_W = DIM_W + 2;
	localparam int NUM_W  = DIM_W + 7;
	localparam int DEN_W  = DIM_W + 4;

	logic [CNT_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic             row_end, frame_end;

	logic [CNT_W-1:0]            pos_s1;
	logic [DIM_W-1:0]            n_s1;
	logic                        neg_s1;
	logic [lig_pkg::FACTOR_W-1:0] b_s1;
	logic                        last_s1;

	logic signed [DIFF_W-1:0] diff;
	logic signed [NUM_W-1:0]  ramp, ten_n;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [lig_pkg::CFG_DATA_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (CMP_W'(v) > CMP_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		else
			r = DIM_W'(v);
		return r;
	endfunction

	// Effective dimensions and end-of-row / end-of-frame tests
	always_comb begin
		w_eff     = eff_dim(frame_width);
		h_eff     = eff_dim(frame_height);
		row_end   = DIM_W'(col_q) >= (w_eff - DIM_W'(1));
		frame_end = DIM_W'(row_q) >= (h_eff - DIM_W'(1));
	end

	// Advance the raster counters on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (ctl.accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	// Capture position, axis length and ramp sign of the accepted pixel
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			pos_s1  <= (direction < lig_pkg::DIR_W'(2)) ? col_q : row_q;
			n_s1    <= (direction < lig_pkg::DIR_W'(2)) ? w_eff : h_eff;
			neg_s1  <= direction[0];
			b_s1    <= factor_tenths;
			last_s1 <= row_end && frame_end;
		end
	end

	// Ramp term (N - 2P) * b and the 10N baseline
	always_comb begin
		diff  = $signed(DIFF_W'(n_s1) - (DIFF_W'(pos_s1) << 1));
		ramp  = NUM_W'(diff) * $signed(NUM_W'({1'b0, b_s1}));
		ten_n = $signed((NUM_W'(n_s1) << 3) + (NUM_W'(n_s1) << 1));
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			num_s2  <= neg_s1 ? ten_n - ramp : ten_n + ramp;
			den_s2  <= (DEN_W'(n_s1) << 3) + (DEN_W'(n_s1) << 1);
			last_s2 <= last_s1;
		end
	end

endmodule

// File: rtl/lig_lane.sv
// One channel lane: p * num, then an 8-step restoring divide by den with clamping.
// Depends on lig_pkg; three copies run side by side under the top level.
`timescale 1ns / 1ps

module lig_lane #(
	parameter int DIM_W = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lig_pkg::lane_ctl_t          ctl,
	input  logic [lig_pkg::CHAN_W-1:0]  p,
	input  logic signed [DIM_W+6:0]     num,
	input  logic [DIM_W+3:0]            den,
	output logic                        done,
	output logic [lig_pkg::CHAN_W-1:0]  q
);

	localparam int NUM_W  = DIM_W + 7;
	localparam int NUMP_W = DIM_W + 5;
	localparam int DEN_W  = DIM_W + 4;
	localparam int PROD_W = NUMP_W + lig_pkg::CHAN_W;
	localparam int DSH_W  = DEN_W + lig_pkg::Q_STEPS;

	lig_pkg::lane_state_t state_q, state_nxt;

	logic [lig_pkg::CHAN_W-1:0]  p_q;
	logic signed [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]            den_q;
	logic [PROD_W-1:0]           rem_q;
	logic [DSH_W-1:0]            dsh_q;
	logic [lig_pkg::CHAN_W-1:0]  quot_q;
	logic [lig_pkg::STEP_W-1:0]  step_q;
	logic                        zero_q, sat_q;
	logic                        fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lig_pkg::LANE_IDLE;
		else
			state_q <= state_nxt;
	end

	// Next state: multiply once, then one quotient bit per cycle
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lig_pkg::LANE_IDLE: if (ctl.start) state_nxt = lig_pkg::LANE_MUL;
			lig_pkg::LANE_MUL:  state_nxt = lig_pkg::LANE_DIV;
			lig_pkg::LANE_DIV: begin
				if (step_q == lig_pkg::STEP_W'(lig_pkg::Q_STEPS - 1))
					state_nxt = lig_pkg::LANE_DONE;
			end
			lig_pkg::LANE_DONE: if (ctl.take) state_nxt = lig_pkg::LANE_IDLE;
			default:            state_nxt = lig_pkg::LANE_IDLE;
		endcase
	end

	assign fits = rem_q >= PROD_W'(dsh_q);

	// Datapath: capture operands, form the product, shift-subtract
	always_ff @(posedge clk) begin
		case (state_q)
			lig_pkg::LANE_IDLE: begin
				p_q    <= p;
				num_q  <= num;
				den_q  <= den;
				step_q <= '0;
			end
			lig_pkg::LANE_MUL: begin
				rem_q  <= PROD_W'(p_q) * PROD_W'(num_q[NUMP_W-1:0]);
				dsh_q  <= DSH_W'(den_q) << (lig_pkg::Q_STEPS - 1);
				zero_q <= num_q[NUM_W-1] || (num_q == '0);
			end
			lig_pkg::LANE_DIV: begin
				// on the first step, flag a quotient of 256 or more
				if (step_q == '0)
					sat_q <= rem_q >= (PROD_W'(dsh_q) << 1);
				if (fits)
					rem_q <= rem_q - PROD_W'(dsh_q);
				quot_q <= {quot_q[lig_pkg::CHAN_W-2:0], fits};
				dsh_q  <= dsh_q >> 1;
				step_q <= step_q + lig_pkg::STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign done = state_q == lig_pkg::LANE_DONE;
	assign q    = zero_q ? '0 : (sat_q ? '1 : quot_q);

endmodule

// File: rtl/linear_illumination_gradient.sv
// Linear illumination gradient: a brightness ramp over a raster pixel stream.
//
// Usage:
//   pix  (sink)   : one three-channel pixel per beat, in raster order. The
//                   block counts column and row itself from reset.
//   grad (source) : one shaded pixel per beat, frame_last set on the last
//                   pixel of each frame.
//   cfg_we/cfg_idx/cfg_data : register writes (direction, factor_tenths,
//                   frame_width, frame_height), to be made only while no
//                   pixel is in flight; the block itself does not enforce this.
// Timing: a pixel passes from its accepting edge to grad through the position
//   capture, the ramp numerator stage, the lane load, one multiply and 8
//   restoring-divide steps in each channel lane, and the output register.
//   One pixel is in the lanes at a time and the input opens the cycle after
//   the hand-off.
// Stall: the output register holds a result while grad.ready is low; the next
//   pixel is already accepted and computed behind it, and waits in the lanes.
// Reset: counters return to the first pixel, registers to their defaults,
//   and all valid flags clear.
// Depends on lig_pkg, lig_if, lig_pos and lig_lane.
`timescale 1ns / 1ps

module linear_illumination_gradient #(
	parameter int MAX_DIM = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	lig_pix_if.sink                            pix,
	lig_res_if.source                          grad,
	input  logic                               cfg_we,
	input  logic [lig_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [lig_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);

	logic [lig_pkg::DIR_W-1:0]      direction_q;
	logic [lig_pkg::FACTOR_W-1:0]   factor_q;
	logic [lig_pkg::CFG_DATA_W-1:0] width_q, height_q;

	logic busy_q, s1_v_q, s2_v_q, out_v_q;
	logic accept, move;

	logic [lig_pkg::CHAN_W-1:0] a_q, b_q, c_q;
	logic signed [DIM_W+6:0]    num_s2;
	logic [DIM_W+3:0]           den_s2;
	logic                       last_s2;

	lig_pkg::pos_ctl_t  pos_ctl;
	lig_pkg::lane_ctl_t lane_ctl;
	logic                       done_a, done_b, done_c;
	logic [lig_pkg::CHAN_W-1:0] q_a, q_b, q_c;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= lig_pkg::RST_DIRECTION;
			factor_q    <= lig_pkg::RST_FACTOR;
			width_q     <= lig_pkg::RST_WIDTH;
			height_q    <= lig_pkg::RST_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_idx)
				lig_pkg::REG_DIRECTION: direction_q <= cfg_data[lig_pkg::DIR_W-1:0];
				lig_pkg::REG_FACTOR:    factor_q    <= cfg_data[lig_pkg::FACTOR_W-1:0];
				lig_pkg::REG_WIDTH:     width_q     <= cfg_data;
				lig_pkg::REG_HEIGHT:    height_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign pix.ready = !busy_q;
	assign accept    = pix.valid && !busy_q;
	assign move      = done_a && (!out_v_q || grad.ready);

	// Item tracking: accept, latch position, start the lanes, hand off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			s1_v_q <= accept;
			s2_v_q <= s1_v_q;
			if (accept)
				busy_q <= 1'b1;
			else if (move)
				busy_q <= 1'b0;
			if (move)
				out_v_q <= 1'b1;
			else if (grad.ready)
				out_v_q <= 1'b0;
		end
	end

	// Hold the pixel channels until the lanes take them
	always_ff @(posedge clk) begin
		if (accept) begin
			a_q <= pix.chan_a;
			b_q <= pix.chan_b;
			c_q <= pix.chan_c;
		end
	end

	assign pos_ctl.accept = accept;
	assign pos_ctl.adv    = s1_v_q;

	lig_pos #(
		.MAX_DIM(MAX_DIM),
		.DIM_W  (DIM_W)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (pos_ctl),
		.direction    (direction_q),
		.factor_tenths(factor_q),
		.frame_width  (width_q),
		.frame_height (height_q),
		.num_s2       (num_s2),
		.den_s2       (den_s2),
		.last_s2      (last_s2)
	);

	assign lane_ctl.start = s2_v_q;
	assign lane_ctl.take  = move;

	lig_lane #(.DIM_W(DIM_W)) u_lane_a (
		.clk(clk), .arst_n(arst_n), .ctl(lane_ctl),
		.p(a_q), .num(num_s2), .den(den_s2), .done(done_a), .q(q_a)
	);

	lig_lane #(.DIM_W(DIM_W)) u_lane_b (
		.clk(clk), .arst_n(arst_n), .ctl(lane_ctl),
		.p(b_q), .num(num_s2), .den(den_s2), .done(done_b), .q(q_b)
	);

	lig_lane #(.DIM_W(DIM_W)) u_lane_c (
		.clk(clk), .arst_n(arst_n), .ctl(lane_ctl),
		.p(c_q), .num(num_s2), .den(den_s2), .done(done_c), .q(q_c)
	);

	// Merge the lane results into the output register
	always_ff @(posedge clk) begin
		if (move) begin
			grad.out_a      <= q_a;
			grad.out_b      <= q_b;
			grad.out_c      <= q_c;
			grad.frame_last <= last_s2;
		end
	end

	assign grad.valid = out_v_q;

	// Lanes run in lockstep
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(done_a == done_b) && (done_b == done_c))
		else $error("channel lanes out of step");

	// A finished result only exists for an item in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_a |-> busy_q)
		else $error("lane result with no item in flight");

	// One item at a time: no accept on the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !pix.ready)
		else $error("input accepted while an item is in flight");

	// Lanes never start while holding an unmoved result
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v_q |-> !done_a)
		else $error("lane started over an undelivered result");

endmodule
